@@ hw/rtl/dtpw_pkg.sv @@
// ----------------------------------------------------------------------------
// dtpw_pkg: shared types and constants for the depth-tested pixel write core
// Holds field widths, operation and register codes, the controller state
// encoding and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dtpw_pkg;

	// Field widths fixed by the interface
	localparam int FrameWidthW  = 10;
	localparam int FrameHeightW = 9;
	localparam int MaskW        = 3;
	localparam int CfgIndexW    = 2;
	localparam int CfgDataW     = 10;
	localparam int CoordInW     = 16;
	localparam int DepthW       = 16;
	localparam int ColorW       = 32;
	localparam int ChanW        = 8;

	// Coordinate bits used in address maths (frame dimensions up to 8192)
	localparam int CoordW       = 13;
	// Comparison width for coordinates against frame dimensions
	localparam int CmpW         = 17;

	localparam logic [DepthW-1:0] ClearDepth  = 16'hFFFF;
	localparam logic [ChanW-1:0]  AlphaOpaque = 8'hFF;
	localparam logic [ChanW-1:0]  ChanMax     = 8'hFF;

	// Pixel operations
	typedef enum logic [1:0] {
		MODE_DEPTH = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_MAX   = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CfgIndexW-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_CHANNEL_MASK = 2'd2
	} cfg_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_READ,
		ST_TEST,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // take the input word
		logic addr_en;   // register row offset product
		logic rd_en;     // read depth entry
		logic test_en;   // compare and conditionally write depth
		logic clr_en;    // write one clear entry and advance sweep
		logic load;      // load result into output register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_frame;  // captured pixel lies inside the frame
		logic clr_done;  // sweep at last entry
		logic out_free;  // output register can take a word this cycle
	} ctrl_stat_t;

endpackage

@@ hw/rtl/dtpw_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtpw_ctrl: sequencing state machine
// Steps one word at a time through capture, address, read, test, clear sweep
// and result hand-off, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module dtpw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_mode,
	output logic                  in_ready,
	input  dtpw_pkg::ctrl_stat_t  stat,
	output dtpw_pkg::ctrl_cmd_t   cmd
);

	dtpw_pkg::state_t state_q;
	dtpw_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtpw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtpw_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (dtpw_pkg::mode_t'(in_mode))
						dtpw_pkg::MODE_DEPTH: state_d = dtpw_pkg::ST_ADDR;
						dtpw_pkg::MODE_CLEAR: state_d = dtpw_pkg::ST_CLEAR;
						default:              state_d = dtpw_pkg::ST_FINISH;
					endcase
				end
			end
			dtpw_pkg::ST_ADDR: begin
				state_d = stat.in_frame ? dtpw_pkg::ST_READ : dtpw_pkg::ST_FINISH;
			end
			dtpw_pkg::ST_READ:  state_d = dtpw_pkg::ST_TEST;
			dtpw_pkg::ST_TEST:  state_d = dtpw_pkg::ST_FINISH;
			dtpw_pkg::ST_CLEAR: begin
				if (stat.clr_done) begin
					state_d = dtpw_pkg::ST_FINISH;
				end
			end
			dtpw_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					state_d = dtpw_pkg::ST_IDLE;
				end
			end
			default: state_d = dtpw_pkg::ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			dtpw_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			dtpw_pkg::ST_ADDR:   cmd.addr_en = 1'b1;
			dtpw_pkg::ST_READ:   cmd.rd_en   = 1'b1;
			dtpw_pkg::ST_TEST:   cmd.test_en = 1'b1;
			dtpw_pkg::ST_CLEAR:  cmd.clr_en  = 1'b1;
			dtpw_pkg::ST_FINISH: cmd.load    = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/dtpw_dpath.sv @@
// ----------------------------------------------------------------------------
// dtpw_dpath: datapath with configuration, depth store and colour logic
// Holds the captured word, frame registers, the depth memory with its clear
// sweep, the colour merge units and the output register.
// ----------------------------------------------------------------------------
module dtpw_dpath #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [dtpw_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [dtpw_pkg::CfgDataW-1:0]       cfg_data,
	input  logic [1:0]                          mode,
	input  logic signed [dtpw_pkg::CoordInW-1:0] pixel_x,
	input  logic signed [dtpw_pkg::CoordInW-1:0] pixel_y,
	input  logic [dtpw_pkg::DepthW-1:0]         pixel_depth,
	input  logic [dtpw_pkg::ColorW-1:0]         tint_color,
	input  logic [dtpw_pkg::ColorW-1:0]         old_color,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [dtpw_pkg::ColorW-1:0]         out_color,
	output logic                                depth_written,
	input  dtpw_pkg::ctrl_cmd_t                 cmd,
	output dtpw_pkg::ctrl_stat_t                stat
);

	localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
	localparam int ProdW      = 2 * dtpw_pkg::CoordW;
	localparam int CmpW       = dtpw_pkg::CmpW;
	localparam int CW         = dtpw_pkg::ChanW;
	localparam logic [CmpW-1:0] MaxW = CmpW'(MAX_WIDTH);
	localparam logic [CmpW-1:0] MaxH = CmpW'(MAX_HEIGHT);
	localparam logic [AW-1:0]   LastAddr = AW'(StoreDepth - 1);

	// Configuration registers
	logic [dtpw_pkg::FrameWidthW-1:0]  frame_width_q;
	logic [dtpw_pkg::FrameHeightW-1:0] frame_height_q;
	logic [dtpw_pkg::MaskW-1:0]        channel_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= dtpw_pkg::FrameWidthW'(512);
			frame_height_q <= dtpw_pkg::FrameHeightW'(256);
			channel_mask_q <= dtpw_pkg::MaskW'(7);
		end else if (cfg_write) begin
			case (dtpw_pkg::cfg_reg_t'(cfg_index))
				dtpw_pkg::REG_FRAME_WIDTH:
					frame_width_q <= cfg_data[dtpw_pkg::FrameWidthW-1:0];
				dtpw_pkg::REG_FRAME_HEIGHT:
					frame_height_q <= cfg_data[dtpw_pkg::FrameHeightW-1:0];
				dtpw_pkg::REG_CHANNEL_MASK:
					channel_mask_q <= cfg_data[dtpw_pkg::MaskW-1:0];
				default: ;
			endcase
		end
	end

	// Captured word
	dtpw_pkg::mode_t                    mode_q;
	logic [dtpw_pkg::CoordInW-1:0]      x_q;
	logic [dtpw_pkg::CoordInW-1:0]      y_q;
	logic [dtpw_pkg::DepthW-1:0]        depth_q;
	logic [dtpw_pkg::ColorW-1:0]        tint_q;
	logic [dtpw_pkg::ColorW-1:0]        old_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= dtpw_pkg::mode_t'(mode);
			x_q     <= pixel_x;
			y_q     <= pixel_y;
			depth_q <= pixel_depth;
			tint_q  <= tint_color;
			old_q   <= old_color;
		end
	end

	// Saturate frame size to the store dimensions
	logic [CmpW-1:0] fw_ext;
	logic [CmpW-1:0] fh_ext;
	logic [CmpW-1:0] w_sat;
	logic [CmpW-1:0] h_sat;

	assign fw_ext = CmpW'(frame_width_q);
	assign fh_ext = CmpW'(frame_height_q);
	assign w_sat  = (fw_ext > MaxW) ? MaxW : fw_ext;
	assign h_sat  = (fh_ext > MaxH) ? MaxH : fh_ext;

	// Frame bounds check
	assign stat.in_frame = !x_q[dtpw_pkg::CoordInW-1] && !y_q[dtpw_pkg::CoordInW-1]
		&& (CmpW'(x_q) < w_sat) && (CmpW'(y_q) < h_sat);

	// Row offset product
	logic [ProdW-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (cmd.addr_en) begin
			prod_s1 <= y_q[dtpw_pkg::CoordW-1:0] * w_sat[dtpw_pkg::CoordW-1:0];
		end
	end

	// Entry address
	logic [ProdW-1:0] addr_sum;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    addr_s2;

	assign addr_sum = ProdW'(x_q[dtpw_pkg::CoordW-1:0]) + prod_s1;
	assign rd_addr  = addr_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			addr_s2 <= rd_addr;
		end
	end

	// Clear sweep position
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= (clr_q == LastAddr) ? '0 : clr_q + AW'(1);
		end
	end

	assign stat.clr_done = (clr_q == LastAddr);

	// Depth store
	logic [dtpw_pkg::DepthW-1:0] store [StoreDepth];
	logic [dtpw_pkg::DepthW-1:0] rd_s2;
	logic                        nearer;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [dtpw_pkg::DepthW-1:0] wr_data;

	assign nearer  = depth_q < rd_s2;
	assign wr_en   = cmd.clr_en || (cmd.test_en && nearer);
	assign wr_addr = cmd.clr_en ? clr_q : addr_s2;
	assign wr_data = cmd.clr_en ? dtpw_pkg::ClearDepth : depth_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_s2 <= store[rd_addr];
		end
	end

	// Test outcome
	logic pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (cmd.capture) begin
			pass_q <= 1'b0;
		end else if (cmd.test_en) begin
			pass_q <= nearer;
		end
	end

	// Colour merge
	logic [3*CW-1:0] mask_bits;
	logic [3*CW-1:0] add_rgb;
	logic [3*CW-1:0] max_rgb;
	logic [dtpw_pkg::ColorW-1:0] color_d;

	assign mask_bits = {{CW{channel_mask_q[2]}}, {CW{channel_mask_q[1]}},
		{CW{channel_mask_q[0]}}};

	// Per-channel saturating add and maximum
	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [CW-1:0] a_c;
		logic [CW-1:0] b_c;
		logic [CW:0]   s_c;

		assign a_c = old_q[c*CW +: CW];
		assign b_c = tint_q[c*CW +: CW];
		assign s_c = {1'b0, a_c} + {1'b0, b_c};
		assign add_rgb[c*CW +: CW] = s_c[CW] ? dtpw_pkg::ChanMax : s_c[CW-1:0];
		assign max_rgb[c*CW +: CW] = (a_c > b_c) ? a_c : b_c;
	end

	always_comb begin
		case (mode_q)
			dtpw_pkg::MODE_DEPTH: begin
				if (pass_q) begin
					color_d = {dtpw_pkg::AlphaOpaque,
						(tint_q[3*CW-1:0] & mask_bits) | (old_q[3*CW-1:0] & ~mask_bits)};
				end else begin
					color_d = old_q;
				end
			end
			dtpw_pkg::MODE_ADD:   color_d = {dtpw_pkg::AlphaOpaque, add_rgb};
			dtpw_pkg::MODE_MAX:   color_d = {dtpw_pkg::AlphaOpaque, max_rgb};
			dtpw_pkg::MODE_CLEAR: color_d = '0;
			default:              color_d = '0;
		endcase
	end

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_color     <= color_d;
			depth_written <= pass_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

@@ hw/rtl/depth_tested_pixel_write_core.sv @@
// ----------------------------------------------------------------------------
// depth_tested_pixel_write_core: z-buffer raster operation unit
// Depth test against a MAX_WIDTH x MAX_HEIGHT 16-bit store, additive and
// maximum colour blends, and a full-store clear.
// ----------------------------------------------------------------------------
// Words are handled one at a time by a state machine around a single-port-write
// depth memory with registered read. Additive and maximum words go from
// acceptance straight to the result hand-off; a depth-test word goes there
// after the frame check when the pixel is outside the frame, and else through
// address multiply, memory read and compare-and-write. A clear sweeps all
// MAX_WIDTH*MAX_HEIGHT store entries, one store entry written per cycle. The
// block returns to idle before the next word is taken. The finished result
// sits in an output register, so the next word is taken while it waits. The
// store holds no defined value after reset: issue a clear before the first
// depth test. Configuration is to be written via cfg_write/cfg_index/cfg_data
// only while no word is in flight; the block itself does not enforce this.
module depth_tested_pixel_write_core #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [dtpw_pkg::CfgIndexW-1:0]       cfg_index,
	input  logic [dtpw_pkg::CfgDataW-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic signed [dtpw_pkg::CoordInW-1:0] pixel_x,
	input  logic signed [dtpw_pkg::CoordInW-1:0] pixel_y,
	input  logic [dtpw_pkg::DepthW-1:0]          pixel_depth,
	input  logic [dtpw_pkg::ColorW-1:0]          tint_color,
	input  logic [dtpw_pkg::ColorW-1:0]          old_color,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dtpw_pkg::ColorW-1:0]          out_color,
	output logic                                 depth_written
);

	dtpw_pkg::ctrl_cmd_t  cmd;
	dtpw_pkg::ctrl_stat_t stat;

	// Sequencer
	dtpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (mode),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath and depth store
	dtpw_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_depth   (pixel_depth),
		.tint_color    (tint_color),
		.old_color     (old_color),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_color     (out_color),
		.depth_written (depth_written),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

@@ tb/sv/tb_depth_tested_pixel_write_core.sv @@
// ----------------------------------------------------------------------------
// tb_depth_tested_pixel_write_core: self-checking bench for the pixel write core
// Drives fragments through the valid/ready input under several idling and
// stalling patterns, predicts each result with a local model of the depth
// store and colour maths, and compares every returned word in order.
// ----------------------------------------------------------------------------
module tb_depth_tested_pixel_write_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxWidth   = 512;
	localparam int MaxHeight  = 256;
	localparam int StoreSize  = MaxWidth * MaxHeight;
	localparam int PhaseWords = 450;
	localparam int HoldCycles = 400;
	localparam int LimitCycles = 2_000_000;

	typedef struct {
		dtpw_pkg::mode_t    mode;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [15:0]        pixel_depth;
		logic [31:0]        tint_color;
		logic [31:0]        old_color;
	} fragment_t;

	typedef struct {
		logic [31:0] color;
		logic        written;
	} pixel_result_t;

	// Tracks the depth store and frame settings, queues expected pixels
	class pixel_scoreboard;
		logic [15:0]   depth_mem [StoreSize];
		logic [9:0]    frame_w;
		logic [8:0]    frame_h;
		logic [2:0]    chan_mask;
		pixel_result_t expected_pixels [$];
		int            mismatches;

		function new();
			foreach (depth_mem[i]) depth_mem[i] = '0;
			frame_w    = 10'd512;
			frame_h    = 9'd256;
			chan_mask  = 3'd7;
			mismatches = 0;
		endfunction

		function void set_reg(dtpw_pkg::cfg_reg_t idx, logic [9:0] val);
			case (idx)
				dtpw_pkg::REG_FRAME_WIDTH:  frame_w   = val;
				dtpw_pkg::REG_FRAME_HEIGHT: frame_h   = val[8:0];
				dtpw_pkg::REG_CHANNEL_MASK: chan_mask = val[2:0];
				default: ;
			endcase
		endfunction

		function int eff_width();
			return (frame_w > MaxWidth) ? MaxWidth : int'(frame_w);
		endfunction

		function int eff_height();
			return (frame_h > MaxHeight) ? MaxHeight : int'(frame_h);
		endfunction

		// Work out the pixel an accepted fragment must produce
		function void note_fragment(fragment_t f);
			pixel_result_t res;
			int            w, h, x, y, idx;
			logic [31:0]   m;
			logic [8:0]    sum;
			logic [7:0]    a, b;
			res.color   = f.old_color;
			res.written = 1'b0;
			case (f.mode)
				dtpw_pkg::MODE_DEPTH: begin
					w = eff_width();
					h = eff_height();
					x = int'(f.pixel_x);
					y = int'(f.pixel_y);
					if (x >= 0 && y >= 0 && x < w && y < h) begin
						idx = x + y * w;
						if (f.pixel_depth < depth_mem[idx]) begin
							m = {8'h00, {8{chan_mask[2]}}, {8{chan_mask[1]}},
								{8{chan_mask[0]}}};
							depth_mem[idx] = f.pixel_depth;
							res.color   = 32'hff000000 | (f.tint_color & m)
								| (f.old_color & ~m);
							res.written = 1'b1;
						end
					end
				end
				dtpw_pkg::MODE_ADD: begin
					res.color = 32'hff000000;
					for (int c = 0; c < 3; c++) begin
						sum = f.old_color[c*8 +: 8] + f.tint_color[c*8 +: 8];
						res.color[c*8 +: 8] = sum[8] ? 8'hff : sum[7:0];
					end
				end
				dtpw_pkg::MODE_MAX: begin
					res.color = 32'hff000000;
					for (int c = 0; c < 3; c++) begin
						a = f.old_color[c*8 +: 8];
						b = f.tint_color[c*8 +: 8];
						res.color[c*8 +: 8] = (a > b) ? a : b;
					end
				end
				default: begin
					foreach (depth_mem[i]) depth_mem[i] = 16'hffff;
					res.color = '0;
				end
			endcase
			expected_pixels.push_back(res);
		endfunction

		function void report_mismatch(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: mismatch: %s", $time, what);
		endfunction

		// Compare a returned word with the oldest expected pixel
		function void check_pixel(logic [31:0] color, logic written);
			pixel_result_t want;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected word colour %h written %b",
					color, written));
				return;
			end
			want = expected_pixels.pop_front();
			if (color !== want.color)
				report_mismatch($sformatf("out_color expected %h got %h",
					want.color, color));
			if (written !== want.written)
				report_mismatch($sformatf("depth_written expected %b got %b",
					want.written, written));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [9:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic [15:0]        pixel_depth;
	logic [31:0]        tint_color;
	logic [31:0]        old_color;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        out_color;
	logic               depth_written;

	pixel_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     stall_pct;
	logic            pressure_go;

	depth_tested_pixel_write_core #(
		.MAX_WIDTH (MaxWidth),
		.MAX_HEIGHT(MaxHeight)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_depth  (pixel_depth),
		.tint_color   (tint_color),
		.old_color    (old_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_color    (out_color),
		.depth_written(depth_written)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		repeat (LimitCycles) @(posedge clk);
		$display("depth_tested_pixel_write_core test failed");
		$finish;
	end

	// Accept result words, check them, and drive out_ready with random stalls
	initial begin
		int hold_left;
		bit pressure_served;
		hold_left       = 0;
		pressure_served = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_pixel(out_color, depth_written);
			if (pressure_go && !pressure_served) begin
				hold_left       = HoldCycles;
				pressure_served = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic fragment_t make_fragment(dtpw_pkg::mode_t m, int x, int y, int d,
			logic [31:0] tint, logic [31:0] old);
		fragment_t f;
		f.mode        = m;
		f.pixel_x     = 16'(x);
		f.pixel_y     = 16'(y);
		f.pixel_depth = 16'(d);
		f.tint_color  = tint;
		f.old_color   = old;
		return f;
	endfunction

	// Build a random fragment, biased towards a few hot pixels and frame edges
	function automatic fragment_t random_fragment();
		fragment_t   f;
		int unsigned sel;
		int          ew, eh;
		ew  = sb.eff_width();
		eh  = sb.eff_height();
		sel = $urandom_range(99);
		f.mode = (sel < 60) ? dtpw_pkg::MODE_DEPTH
			: (sel < 80) ? dtpw_pkg::MODE_ADD : dtpw_pkg::MODE_MAX;
		sel = $urandom_range(99);
		if (sel < 55) begin
			f.pixel_x = 16'($urandom_range(5));
			f.pixel_y = 16'($urandom_range(3));
		end else if (sel < 80) begin
			f.pixel_x = 16'($urandom_range(ew));
			f.pixel_y = 16'($urandom_range(eh));
		end else if (sel < 90) begin
			f.pixel_x = 16'(($urandom_range(1) ? ew : 0) - int'($urandom_range(1)));
			f.pixel_y = 16'(($urandom_range(1) ? eh : 0) - int'($urandom_range(1)));
		end else begin
			f.pixel_x = 16'($urandom);
			f.pixel_y = 16'($urandom);
		end
		sel = $urandom_range(99);
		if (sel < 60)
			f.pixel_depth = 16'($urandom);
		else if (sel < 80)
			f.pixel_depth = 16'($urandom_range(255));
		else if (sel < 90)
			f.pixel_depth = 16'hffff;
		else
			f.pixel_depth = 16'h0000;
		f.tint_color = $urandom;
		f.old_color  = $urandom;
		return f;
	endfunction

	// Offer one word, idling first at random; returns at the accepting edge
	task automatic offer_fragment(input fragment_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= f.mode;
		pixel_x     <= f.pixel_x;
		pixel_y     <= f.pixel_y;
		pixel_depth <= f.pixel_depth;
		tint_color  <= f.tint_color;
		old_color   <= f.old_color;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_fragment(f);
	endtask

	// Drop valid and hold until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all three frame registers back to back
	task automatic write_frame_regs(input logic [9:0] w, input logic [9:0] h,
			input logic [9:0] m);
		cfg_write <= 1'b1;
		cfg_index <= dtpw_pkg::REG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		sb.set_reg(dtpw_pkg::REG_FRAME_WIDTH, w);
		cfg_index <= dtpw_pkg::REG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		sb.set_reg(dtpw_pkg::REG_FRAME_HEIGHT, h);
		cfg_index <= dtpw_pkg::REG_CHANNEL_MASK;
		cfg_data  <= m;
		@(posedge clk);
		sb.set_reg(dtpw_pkg::REG_CHANNEL_MASK, m);
		cfg_write <= 1'b0;
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		stall_pct   <= 0;
		pressure_go <= 1'b0;
		arst_n      <= 1'b0;
		cfg_write   <= 1'b0;
		cfg_index   <= dtpw_pkg::REG_FRAME_WIDTH;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		mode        <= dtpw_pkg::MODE_ADD;
		pixel_x     <= '0;
		pixel_y     <= '0;
		pixel_depth <= '0;
		tint_color  <= '0;
		old_color   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: blends, out-of-frame tests before any clear, then the store
		write_frame_regs(10'd512, 10'd256, 10'd7);
		offer_fragment(make_fragment(dtpw_pkg::MODE_ADD, 0, 0, 0,
			32'hffffffff, 32'hffffffff));
		offer_fragment(make_fragment(dtpw_pkg::MODE_ADD, 0, 0, 0,
			32'h00000000, 32'h00000000));
		offer_fragment(make_fragment(dtpw_pkg::MODE_ADD, 0, 0, 0,
			32'h12807fe0, 32'hab80811f));
		offer_fragment(make_fragment(dtpw_pkg::MODE_MAX, 0, 0, 0,
			32'h00ff0001, 32'hff00ff00));
		offer_fragment(make_fragment(dtpw_pkg::MODE_MAX, 0, 0, 0,
			32'h7f102030, 32'h80302010));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, -1, 0, 0,
			32'h11223344, 32'h55667788));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 512, 0, 0,
			32'h11223344, 32'h55667788));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 256, 0,
			32'h11223344, 32'h55667788));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, -32768, 32767, 0,
			32'h1, 32'h2));
		offer_fragment(make_fragment(dtpw_pkg::MODE_CLEAR, 0, 0, 0,
			32'hffffffff, 32'hffffffff));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 0, 16'h1234,
			32'haabbccdd, 32'h0));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 0, 16'h1234,
			32'haabbccdd, 32'h0));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 0, 16'h0000,
			32'h00ff00ff, 32'h1));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 511, 255, 16'hffff,
			32'h5, 32'h6));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 511, 255, 16'hfffe,
			32'h5, 32'h6));
		drain();

		// Zero frame size: everything is outside
		write_frame_regs(10'd0, 10'd0, 10'd0);
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 0, 0,
			32'h12345678, 32'h9abcdef0));
		drain();

		// Oversized frame saturates to the store size
		write_frame_regs(10'd1023, 10'd1023, 10'd5);
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 511, 255, 0,
			32'hfedcba98, 32'h01234567));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 512, 0, 0,
			32'hfedcba98, 32'h01234567));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 256, 0,
			32'hfedcba98, 32'h01234567));
		drain();

		// Single-pixel frame
		write_frame_regs(10'd1, 10'd1, 10'd2);
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 0, 0,
			32'h0000ff00, 32'h00000000));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 1, 0, 0,
			32'h0000ff00, 32'h00000000));
		offer_fragment(make_fragment(dtpw_pkg::MODE_DEPTH, 0, 1, 0,
			32'h0000ff00, 32'h00000000));
		drain();

		// Random phases: free run, idle sender, stalling receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_frame_regs(10'd512, 10'd256, 10'd7);
				1: write_frame_regs(10'd1023, 10'd511, 10'd0);
				2: write_frame_regs(10'($urandom_range(40, 1)), 10'($urandom_range(20, 1)),
					10'($urandom_range(7)));
				default: write_frame_regs(10'($urandom_range(1023, 1)),
					10'($urandom_range(511, 1)), 10'($urandom_range(7)));
			endcase
			send_idle_pct = (phase == 1 || phase == 2) ? ((phase == 1) ? 88 : 0)
				: ((phase == 3) ? 17 : 0);
			stall_pct <= (phase == 2) ? 88 : (phase == 3) ? 17 : 0;
			if (phase == 0 || phase == 2)
				offer_fragment(make_fragment(dtpw_pkg::MODE_CLEAR, $urandom, $urandom,
					$urandom, $urandom, $urandom));
			for (int n = 0; n < PhaseWords; n++) begin
				// Stall the receiver for a long stretch while words keep coming
				if (phase == 0 && n == 100)
					pressure_go <= 1'b1;
				offer_fragment(random_fragment());
			end
			drain();
		end

		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("depth_tested_pixel_write_core test passed");
		else
			$display("depth_tested_pixel_write_core test failed");
		$finish;
	end

endmodule
